/* sv/cbpc_pkg.sv */
// Package for the per-channel circuit breaker: types, codes and reset values.
`default_nettype none

package cbpc_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_CHANNELS_DEF = 16;
    localparam int TIME_BITS_DEF    = 32;

    // Fixed field widths
    localparam int MODE_W     = 3;
    localparam int CHANNEL_W  = 4;
    localparam int STATE_W    = 2;
    localparam int FAIL_W     = 16;
    localparam int PROBE_W    = 8;
    localparam int COOLDOWN_W = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBES    = 2'd2;

    // Configuration reset values
    localparam logic [FAIL_W-1:0]     THRESHOLD_RST = 16'd5;
    localparam logic [COOLDOWN_W-1:0] COOLDOWN_RST  = 31'd30;
    localparam logic [PROBE_W-1:0]    PROBES_RST    = 8'd1;

    localparam logic [FAIL_W-1:0] FAIL_MAX = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_REQUEST = 3'd0,
        MODE_SUCCESS = 3'd1,
        MODE_FAILURE = 3'd2,
        MODE_TICK    = 3'd3,
        MODE_STATUS  = 3'd4
    } mode_t;

    typedef enum logic [STATE_W-1:0] {
        BRK_CLOSED = 2'd0,
        BRK_OPEN   = 2'd1,
        BRK_HALF   = 2'd2
    } brk_state_t;

    typedef struct packed {
        brk_state_t        state;
        logic [FAIL_W-1:0] fails;
        logic [PROBE_W-1:0] probes;
    } entry_t;

    typedef struct packed {
        logic [FAIL_W-1:0]     threshold;
        logic [COOLDOWN_W-1:0] cooldown;
        logic [PROBE_W-1:0]    probe_limit;
    } cfg_t;

    typedef struct packed {
        logic allowed;
        logic stamp;    // load opened_at with the current time
    } upd_t;

endpackage

`default_nettype wire

/* sv/circuit_breaker_per_channel_core.sv */
// Top level of the per-channel circuit breaker (closed, open, half open).
// Throughput: one transaction per cycle; busy stays low, done strobes for one cycle.
// The receiver cannot stall; done flags each result for exactly one cycle.
// The input register feeds one pass of entry logic that writes the result register.
// Reset (rst_n low, async) closes every channel, zeroes counters and time, restores config.
`default_nettype none

module circuit_breaker_per_channel_core
    import cbpc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int TIME_BITS    = TIME_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // item channel
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [MODE_W-1:0]     mode,
    input  wire logic [CHANNEL_W-1:0]  channel,

    // result channel
    output logic                       done,
    output logic                       allowed,
    output logic [STATE_W-1:0]         breaker_state,
    output logic [FAIL_W-1:0]          failure_count,

    // configuration write channel
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Only channels that the 4-bit channel field can name get storage.
    localparam int REACH = 1 << CHANNEL_W;
    localparam int DEPTH = (NUM_CHANNELS < REACH) ? NUM_CHANNELS : REACH;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration registers; write them only while the block is idle (not enforced here).
    cfg_t cfg_reg;

    // Input register
    logic                 s1_valid_reg;
    logic [MODE_W-1:0]    s1_mode_reg;
    logic [CHANNEL_W-1:0] s1_channel_reg;

    // Channel table and time base
    entry_t               ent_reg [DEPTH];
    logic [TIME_BITS-1:0] opened_at_reg [DEPTH];
    logic [TIME_BITS-1:0] now_reg;

    // Result register
    logic               done_reg;
    logic               allowed_reg;
    logic [STATE_W-1:0] state_reg;
    logic [FAIL_W-1:0]  fails_reg;

    logic               done_next;
    logic               allowed_next;
    logic [STATE_W-1:0] state_next;
    logic [FAIL_W-1:0]  fails_next;

    mode_t            s1_mode;
    logic             in_range;
    logic             is_tick;
    logic             ent_we;
    logic [IDX_W-1:0] idx;
    entry_t           cur_ent;
    entry_t           nxt_ent;
    upd_t             upd;

    // The pipeline never backs up, so every cycle takes a transaction.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Hold the config registers; ignore writes to indexes past the list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold   <= THRESHOLD_RST;
            cfg_reg.cooldown    <= COOLDOWN_RST;
            cfg_reg.probe_limit <= PROBES_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: cfg_reg.threshold   <= cfg_data[FAIL_W-1:0];
                CFG_COOLDOWN:  cfg_reg.cooldown    <= cfg_data[COOLDOWN_W-1:0];
                CFG_PROBES:    cfg_reg.probe_limit <= cfg_data[PROBE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Capture the transaction into the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            s1_mode_reg    <= mode;
            s1_channel_reg <= channel;
        end
    end

    // Decode the registered item. An out-of-range channel touches nothing.
    assign s1_mode  = mode_t'(s1_mode_reg);
    assign is_tick  = (s1_mode == MODE_TICK);
    assign in_range = 32'(s1_channel_reg) < 32'(NUM_CHANNELS);
    assign idx      = in_range ? s1_channel_reg[IDX_W-1:0] : '0;
    assign cur_ent  = ent_reg[idx];
    assign ent_we   = s1_valid_reg && in_range && !is_tick;

    cbpc_update #(
        .TIME_BITS (TIME_BITS)
    ) u_update (
        .mode      (s1_mode),
        .cur       (cur_ent),
        .opened_at (opened_at_reg[idx]),
        .now       (now_reg),
        .cfg       (cfg_reg),
        .nxt       (nxt_ent),
        .upd       (upd)
    );

    // Write back the channel entry; reset closes every channel at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                ent_reg[i].state  <= BRK_CLOSED;
                ent_reg[i].fails  <= '0;
                ent_reg[i].probes <= '0;
            end
        end
        else if (ent_we)
        begin
            ent_reg[idx] <= nxt_ent;
        end
    end

    // Stamp the opening time; entries hold junk until first opened.
    always_ff @(posedge clk)
    begin
        if (ent_we && upd.stamp)
        begin
            opened_at_reg[idx] <= now_reg;
        end
    end

    // Advance time on every tick, wrapping at TIME_BITS.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg <= '0;
        end
        else if (s1_valid_reg && is_tick)
        begin
            now_reg <= now_reg + 1'b1;
        end
    end

    // Build the result: ticks and out-of-range channels report all zeros.
    always_comb
    begin
        done_next    = s1_valid_reg;
        allowed_next = 1'b0;
        state_next   = '0;
        fails_next   = '0;
        if (in_range && !is_tick)
        begin
            allowed_next = upd.allowed;
            state_next   = nxt_ent.state;
            fails_next   = nxt_ent.fails;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            allowed_reg <= allowed_next;
            state_reg   <= state_next;
            fails_reg   <= fails_next;
        end
    end

    assign done          = done_reg;
    assign allowed       = allowed_reg;
    assign breaker_state = state_reg;
    assign failure_count = fails_reg;

    // Every registered item yields exactly one result in the next cycle.
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |=> done_reg)
        else $error("registered item produced no result");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |=> !done_reg)
        else $error("result strobe without a registered item");

    // Only a request may be let through.
    a_allow_req: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && allowed_reg |-> $past(s1_mode_reg) == MODE_REQUEST)
        else $error("allowed raised on a non-request");

    // The table never holds the unused state code.
    a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && in_range |-> cur_ent.state != 2'd3)
        else $error("channel entry holds an illegal state");

    // A recorded failure always leaves a nonzero count.
    a_fail_count: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && in_range && s1_mode == MODE_FAILURE |=> failure_count != '0)
        else $error("failure left a zero count");

endmodule

`default_nettype wire

/* sv/cbpc_update.sv */
// Next-entry logic of one breaker channel for one transaction.
`default_nettype none

module cbpc_update
    import cbpc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  wire mode_t                mode,
    input  wire entry_t               cur,
    input  wire logic [TIME_BITS-1:0] opened_at,
    input  wire logic [TIME_BITS-1:0] now,
    input  wire cfg_t                 cfg,
    output entry_t                    nxt,
    output upd_t                      upd
);

    localparam int CMP_W = (TIME_BITS > COOLDOWN_W) ? TIME_BITS : COOLDOWN_W;

    logic [TIME_BITS-1:0] elapsed;
    logic                 cooled;
    logic [FAIL_W-1:0]    fails_inc;

    assign elapsed   = now - opened_at;
    assign cooled    = CMP_W'(elapsed) >= CMP_W'(cfg.cooldown);
    assign fails_inc = (cur.fails == FAIL_MAX) ? cur.fails : cur.fails + 1'b1;

    always_comb
    begin
        nxt         = cur;
        upd.allowed = 1'b0;
        upd.stamp   = 1'b0;
        unique case (mode)
            MODE_REQUEST:
            begin
                unique case (cur.state)
                    BRK_CLOSED:
                    begin
                        upd.allowed = 1'b1;
                    end
                    BRK_OPEN:
                    begin
                        if (cooled)
                        begin
                            nxt.state   = BRK_HALF;
                            nxt.probes  = '0;
                            upd.allowed = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (cur.probes < cfg.probe_limit)
                        begin
                            nxt.probes  = cur.probes + 1'b1;
                            upd.allowed = 1'b1;
                        end
                    end
                endcase
            end
            MODE_SUCCESS:
            begin
                nxt.state  = BRK_CLOSED;
                nxt.fails  = '0;
                nxt.probes = '0;
            end
            MODE_FAILURE:
            begin
                nxt.fails = fails_inc;
                if (cur.state == BRK_CLOSED)
                begin
                    if (fails_inc >= cfg.threshold)
                    begin
                        nxt.state = BRK_OPEN;
                        upd.stamp = 1'b1;
                    end
                end
                else if (cur.state == BRK_HALF)
                begin
                    nxt.state = BRK_OPEN;
                    upd.stamp = 1'b1;
                end
            end
            default:
            begin
                // tick, status read and unused codes leave the entry alone
            end
        endcase
    end

endmodule

`default_nettype wire
